// ===== rtl/core/vertical_depth_remap_coordinates_unit_assert.svh =====
// Assertion macros shared by the depth remap checker.
`ifndef VERTICAL_DEPTH_REMAP_COORDINATES_UNIT_ASSERT_SVH
`define VERTICAL_DEPTH_REMAP_COORDINATES_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define VDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never shows outside reset.
`define VDR_ASSERT_NEVER(lbl, cond, msg) \
  `VDR_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/vdr_pkg.sv =====
// Shared constants, layer height table and helpers of the depth remap unit.
`timescale 1ns / 1ps
package vdr_pkg;

  localparam int TableEntries  = 50;
  localparam int MaxSize       = 1024;
  localparam int CoordFracBits = 16;

  localparam int SizeW   = 11;
  localparam int IdxW    = 10;
  localparam int CoordW  = CoordFracBits + 1;
  localparam int AddrW   = 30;
  localparam int DepthW  = 21;
  localparam int TblIdxW = $clog2(TableEntries + 1);
  localparam int GrpCnt  = (TableEntries + 7) / 8;
  localparam int DeltaW  = 17;

  localparam int DivQW = 21;
  localparam int DivDW = 22;
  localparam int DivNW = DivQW + DivDW;

  localparam int InTdataW  = ((3 * IdxW + 7) / 8) * 8;
  localparam int OutTdataW = ((3 * CoordW + AddrW + 7) / 8) * 8;

  localparam logic [DepthW-1:0] DepthMaxQ8 = DepthW'(1408000);
  localparam logic [CoordW-1:0] CoordOne   = CoordW'(1) << CoordFracBits;

  localparam logic [1:0] RegSizeX  = 2'd0;
  localparam logic [1:0] RegSizeY  = 2'd1;
  localparam logic [1:0] RegSizeZ  = 2'd2;
  localparam logic [1:0] RegInvert = 2'd3;

  localparam logic [DepthW-1:0] LayerQ8 [TableEntries] = '{
    21'd1289,    21'd3866,    21'd6456,    21'd9052,    21'd11668,
    21'd14298,   21'd16963,   21'd19662,   21'd22420,   21'd25248,
    21'd28185,   21'd31259,   21'd34537,   21'd38079,   21'd41998,
    21'd46416,   21'd51523,   21'd57543,   21'd64785,   21'd73613,
    21'd84482,   21'd97885,   21'd114362,  21'd134395,  21'd158388,
    21'd186545,  21'd218878,  21'd255159,  21'd295009,  21'd337920,
    21'd383375,  21'd430863,  21'd479946,  21'd530240,  21'd581458,
    21'd633354,  21'd685763,  21'd738534,  21'd791583,  21'd844823,
    21'd898209,  21'd951698,  21'd1005263, 21'd1058880, 21'd1112540,
    21'd1166226, 21'd1219935, 21'd1273654, 21'd1327388, 21'd1381125
  };

  function automatic logic [DepthW-1:0] tbl_at(input logic [TblIdxW-1:0] idx);
    logic [DepthW-1:0] val;
    val = '0;
    if (int'(idx) < TableEntries) begin
      val = LayerQ8[idx];
    end
    return val;
  endfunction

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] r;
    r = s;
    if (s == '0) begin
      r = SizeW'(1);
    end else if (s > SizeW'(MaxSize)) begin
      r = SizeW'(MaxSize);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/vdr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module vdr_div import vdr_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  output logic [DivQW-1:0] quo_o
);

  logic [DivDW-1:0] rem_q [DivQW+1];
  logic [DivQW-1:0] low_q [DivQW+1];
  logic [DivDW-1:0] den_q [DivQW+1];
  logic [DivQW-1:0] quo_q [DivQW+1];

  logic [DivDW-1:0] rem_d [DivQW];
  logic [DivQW-1:0] quo_d [DivQW];

  always_comb begin
    for (int k = 0; k < DivQW; k++) begin
      logic [DivDW:0] trial;
      logic           ge;
      trial = {rem_q[k], low_q[k][DivQW-1]};
      ge    = trial >= {1'b0, den_q[k]};
      rem_d[k] = ge ? DivDW'(trial - {1'b0, den_q[k]}) : trial[DivDW-1:0];
      quo_d[k] = {quo_q[k][DivQW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[DivNW-1:DivQW];
      low_q[0] <= num_i[DivQW-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      for (int k = 0; k < DivQW; k++) begin
        rem_q[k+1] <= rem_d[k];
        low_q[k+1] <= {low_q[k][DivQW-2:0], 1'b0};
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= quo_d[k];
      end
    end
  end

  assign quo_o = quo_q[DivQW];

endmodule

// ===== rtl/core/vertical_depth_remap_coordinates_unit.sv =====
// Top level of the vertical depth remap coordinate and address generator.
// One voxel index beat in, one coordinate and address beat out, one beat per cycle
// sustained while the output is not stalled. The path holds two chained 21-stage
// restoring dividers (depth scaling, then layer interpolation) plus lookup and
// output stages. The whole pipeline holds while the output beat is stalled. Write the
// size and inversion registers only while no beat is in flight.
`timescale 1ns / 1ps
module vertical_depth_remap_coordinates_unit import vdr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_addr_i,
  input  logic [SizeW-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // voxel_x, voxel_y, voxel_z
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // coord_x, coord_y, coord_z, out_address
  output logic [OutTdataW-1:0] m_axis_tdata
);

  localparam int StA = 1;
  localparam int StB = StA + DivQW + 1;
  localparam int StE = StB + 3;
  localparam int StH = StB + 6;
  localparam int StZ = StH + DivQW + 1;
  localparam int Lat = StZ + 1;
  localparam int StAd = 5;

  logic [SizeW-1:0] size_x_q, size_y_q, size_z_q;
  logic             invert_q;
  logic [SizeW-1:0] sx, sy, sz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SizeW'(128);
      size_y_q <= SizeW'(128);
      size_z_q <= SizeW'(128);
      invert_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegSizeX:  size_x_q <= cfg_wdata_i;
        RegSizeY:  size_y_q <= cfg_wdata_i;
        RegSizeZ:  size_z_q <= cfg_wdata_i;
        RegInvert: invert_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign sx = eff_size(size_x_q);
  assign sy = eff_size(size_y_q);
  assign sz = eff_size(size_z_q);

  logic           en;
  logic [Lat:StA] vld_q;

  assign en            = !vld_q[Lat] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-1:StA], s_axis_tvalid};
    end
  end

  logic [IdxW-1:0] x1_q, y1_q, z1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q <= s_axis_tdata[IdxW-1:0];
      y1_q <= s_axis_tdata[2*IdxW-1:IdxW];
      z1_q <= s_axis_tdata[3*IdxW-1:2*IdxW];
    end
  end

  logic [DivNW-1:0] num_x, num_y, num_z;
  logic [DivDW-1:0] den_x, den_y, den_z;
  logic [31:0]      zm;
  logic [2:0]       sat1;

  always_comb begin
    num_x = (DivNW'({x1_q, 1'b1}) << CoordFracBits) + DivNW'(sx);
    num_y = (DivNW'({y1_q, 1'b1}) << CoordFracBits) + DivNW'(sy);
    zm    = 32'({z1_q, 1'b1}) * 32'(DepthMaxQ8);
    num_z = DivNW'(zm) + DivNW'(sz);
    den_x = DivDW'({sx, 1'b0});
    den_y = DivDW'({sy, 1'b0});
    den_z = DivDW'({sz, 1'b0});
    sat1  = {{1'b0, z1_q} >= sz, {1'b0, y1_q} >= sy, {1'b0, x1_q} >= sx};
  end

  logic [DivQW-1:0] qx, qy, qz;

  vdr_div u_div_x (.clk_i(clk_i), .en_i(en), .num_i(num_x), .den_i(den_x), .quo_o(qx));
  vdr_div u_div_y (.clk_i(clk_i), .en_i(en), .num_i(num_y), .den_i(den_y), .quo_o(qy));
  vdr_div u_div_z (.clk_i(clk_i), .en_i(en), .num_i(num_z), .den_i(den_z), .quo_o(qz));

  logic [2:0] sat_dl [StA+1:StB];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat_dl[StA+1] <= sat1;
      for (int s = StA + 2; s <= StB; s++) begin
        sat_dl[s] <= sat_dl[s-1];
      end
    end
  end

  // address: x + size_x * (y + size_y * z)
  logic [20:0]      m1_q;
  logic [21:0]      t3_q;
  logic [32:0]      m4_q;
  logic [IdxW-1:0]  ya_q, xa_q, xb_q, xc_q;
  logic [AddrW-1:0] addr_dl [StAd:Lat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= 21'(sy) * 21'(z1_q);
      ya_q <= y1_q;
      xa_q <= x1_q;
      t3_q <= 22'(m1_q) + 22'(ya_q);
      xb_q <= xa_q;
      m4_q <= 33'(t3_q) * 33'(sx);
      xc_q <= xb_q;
      addr_dl[StAd] <= AddrW'(m4_q + 33'(xc_q));
      for (int s = StAd + 1; s <= Lat; s++) begin
        addr_dl[s] <= addr_dl[s-1];
      end
    end
  end

  logic [CoordW-1:0]   cx, cy;
  logic [2*CoordW-1:0] xy_dl [StB+1:Lat];
  logic [DepthW-1:0]   vsel, vflip;

  always_comb begin
    cx    = sat_dl[StB][0] ? CoordOne : CoordW'(qx[CoordFracBits-1:0]);
    cy    = sat_dl[StB][1] ? CoordOne : CoordW'(qy[CoordFracBits-1:0]);
    vsel  = sat_dl[StB][2] ? DepthMaxQ8 : qz[DepthW-1:0];
    vflip = invert_q ? DepthMaxQ8 - vsel : vsel;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xy_dl[StB+1] <= {cy, cx};
      for (int s = StB + 2; s <= Lat; s++) begin
        xy_dl[s] <= xy_dl[s-1];
      end
    end
  end

  // layer search: compares with group counts, then index and neighbors
  logic [DepthW-1:0]  v_c_q, v_d_q, v_e_q;
  logic [3:0]         grp_d [GrpCnt];
  logic [3:0]         grp_q [GrpCnt];
  logic [TblIdxW-1:0] idx_e;

  always_comb begin
    for (int g = 0; g < GrpCnt; g++) begin
      grp_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if ((g * 8 + b) < TableEntries) begin
          if (tbl_at(TblIdxW'(g * 8 + b)) < v_c_q) begin
            grp_d[g] = grp_d[g] + 4'd1;
          end
        end
      end
    end
    idx_e = '0;
    for (int g = 0; g < GrpCnt; g++) begin
      idx_e = idx_e + TblIdxW'(grp_q[g]);
    end
  end

  logic [1:0]         flg_dl [StE:StZ];
  logic [DepthW-1:0]  lo_e_q, hi_e_q;
  logic [TblIdxW-1:0] idx_e_q, im1_f_q;
  logic [DeltaW-1:0]  d_f_q, vl_f_q;
  logic [DivDW-1:0]   p_g_q, vl_g_q, den_g_q, den_h_q;
  logic [DivNW-1:0]   num_h_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_c_q <= vflip;
      v_d_q <= v_c_q;
      grp_q <= grp_d;
      v_e_q   <= v_d_q;
      idx_e_q <= idx_e;
      lo_e_q  <= tbl_at(idx_e - TblIdxW'(1));
      hi_e_q  <= tbl_at(idx_e);
      flg_dl[StE] <= {idx_e == TblIdxW'(TableEntries), idx_e == '0};
      for (int s = StE + 1; s <= StZ; s++) begin
        flg_dl[s] <= flg_dl[s-1];
      end
      d_f_q   <= DeltaW'(hi_e_q - lo_e_q);
      vl_f_q  <= DeltaW'(v_e_q - lo_e_q);
      im1_f_q <= idx_e_q - TblIdxW'(1);
      p_g_q   <= DivDW'(im1_f_q) * DivDW'(d_f_q);
      den_g_q <= DivDW'(d_f_q) * DivDW'(TableEntries - 1);
      vl_g_q  <= DivDW'(vl_f_q);
      num_h_q <= (DivNW'(p_g_q + vl_g_q) << CoordFracBits) + DivNW'(den_g_q >> 1);
      den_h_q <= den_g_q;
    end
  end

  logic [DivQW-1:0]  qi;
  logic [CoordW-1:0] pz, pz_out, cz_q;

  vdr_div u_div_i (.clk_i(clk_i), .en_i(en), .num_i(num_h_q), .den_i(den_h_q), .quo_o(qi));

  always_comb begin
    if (flg_dl[StZ][0]) begin
      pz = '0;
    end else if (flg_dl[StZ][1]) begin
      pz = CoordOne;
    end else begin
      pz = qi[CoordW-1:0];
    end
    pz_out = invert_q ? CoordOne - pz : pz;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cz_q <= pz_out;
    end
  end

  assign m_axis_tdata = OutTdataW'({addr_dl[Lat], cz_q, xy_dl[Lat]});

endmodule

// ===== rtl/core/vdr_chk.sv =====
// Port-level checker of the depth remap unit and its bind.
`timescale 1ns / 1ps
`include "vertical_depth_remap_coordinates_unit_assert.svh"
module vdr_chk import vdr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [1:0]           cfg_addr_i,
  input logic [SizeW-1:0]     cfg_wdata_i,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [InTdataW-1:0]  s_axis_tdata,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  `VDR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")
  `VDR_ASSERT(a_in_ready, m_axis_tready || !m_axis_tvalid |-> s_axis_tready, "input blocked while output drains")
  `VDR_ASSERT_NEVER(a_cx_range, m_axis_tvalid && m_axis_tdata[CoordW-1:0] > CoordOne, "coord_x above one")
  `VDR_ASSERT_NEVER(a_cz_range, m_axis_tvalid && m_axis_tdata[3*CoordW-1:2*CoordW] > CoordOne, "coord_z above one")

endmodule

bind vertical_depth_remap_coordinates_unit vdr_chk u_vdr_chk (.*);
